/* rtl/bounded_queue_search_stats_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded queue with search and statistics
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_QUEUE_SEARCH_STATS_DEFINES_SVH
`define BOUNDED_QUEUE_SEARCH_STATS_DEFINES_SVH

// Same-cycle implication: when pre holds, post must hold in that cycle.
`define BQSS_ASSERT_IMPL(lbl, clk_sig, rst_n_sig, pre, post) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (pre) |-> (post)) \
		else $error("bqss: same-cycle check failed");

// Next-cycle implication: when pre holds, post must hold in the following cycle.
`define BQSS_ASSERT_NEXT(lbl, clk_sig, rst_n_sig, pre, post) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (pre) |=> (post)) \
		else $error("bqss: next-cycle check failed");

`endif

/* rtl/bqss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqss_pkg
// Field widths, operation and status codes, and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bqss_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 16;

	localparam int OPCODE_W   = 3;
	localparam int VALUE_W    = 16;
	localparam int POSITION_W = 5;
	localparam int STATUS_W   = 2;
	localparam int MASK_W     = 16;
	localparam int MASK_IDX_W = 4;
	localparam int COUNT_W    = 5;
	localparam int TOTAL_W    = 20;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ENQUEUE = 3'd0,
		OP_DEQUEUE = 3'd1,
		OP_SEARCH  = 3'd2,
		OP_EDIT    = 3'd3,
		OP_CLEAR   = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic fetch;
		logic walk_init;
		logic walk_run;
		logic div_start;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_fetch;
		logic walk_done;
		logic div_done;
	} dp_stat_t;

endpackage

/* rtl/bqss_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqss request and response channels
// Valid/ready channels carrying one operation item and one result item.
// ----------------------------------------------------------------------------
interface bqss_req_if import bqss_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [OPCODE_W-1:0]          opcode;
	logic signed [VALUE_W-1:0]    value;
	logic [POSITION_W-1:0]        position;

	modport source (output valid, opcode, value, position, input ready);
	modport sink (input valid, opcode, value, position, output ready);
endinterface

interface bqss_rsp_if import bqss_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [STATUS_W-1:0]          status;
	logic signed [VALUE_W-1:0]    item;
	logic [MASK_W-1:0]            match_mask;
	logic [COUNT_W-1:0]           count;
	logic signed [TOTAL_W-1:0]    total;
	logic signed [VALUE_W-1:0]    average;
	logic signed [VALUE_W-1:0]    largest;
	logic signed [VALUE_W-1:0]    smallest;

	modport source (output valid, status, item, match_mask, count, total, average,
		largest, smallest, input ready);
	modport sink (input valid, status, item, match_mask, count, total, average,
		largest, smallest, output ready);
endinterface

/* rtl/bounded_queue_search_stats.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_queue_search_stats
// Bounded FIFO of signed entries with enqueue, dequeue, search, edit and
// clear, answering every operation with its status and queue statistics.
// ----------------------------------------------------------------------------
// Usage: each item on the req channel carries an opcode, a value and a
// 1-based position; each one produces exactly one item on the rsp channel
// with status, the dequeued or replaced entry, the search match mask, and
// count, total, average, largest and smallest of the entries held afterward.
// Both channels are valid/ready; an item moves when valid and ready are high
// at a rising clock edge.
// The time from acceptance to result is set by the entry walk, which reads
// one entry a cycle from the single-read-port entry memory, and by the
// bit-serial divider that forms the average one quotient bit per cycle;
// dequeue and edit add a fetch step when they find an entry to take or replace.
// One item is worked on at a time. The result sits in an output register,
// so the next item is accepted while a result still waits to be taken; a
// stalled receiver holds the block only once the next result is ready.
// Reset empties the queue and drops any pending result; the entries
// themselves are not cleared and never need to be.
// ----------------------------------------------------------------------------
`include "bounded_queue_search_stats_defines.svh"

module bounded_queue_search_stats import bqss_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bqss_req_if.sink   req,
	bqss_rsp_if.source rsp
);

	// Commands from the sequencer and conditions fed back to it.
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	bqss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// The datapath owns the entry ring, the walk, the divider and the
	// result register whose contents the rsp channel presents.
	bqss_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.opcode     (req.opcode),
		.value      (req.value),
		.position   (req.position),
		.status     (rsp.status),
		.item       (rsp.item),
		.match_mask (rsp.match_mask),
		.count      (rsp.count),
		.total      (rsp.total),
		.average    (rsp.average),
		.largest    (rsp.largest),
		.smallest   (rsp.smallest)
	);

	// Only one operation is in flight: acceptance closes the request side.
	`BQSS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req.valid && req.ready, !req.ready)

	// A new result is never written over one that has not been taken.
	`BQSS_ASSERT_IMPL(a_load_when_free, clk, arst_n, cmd.load_out, !rsp.valid || rsp.ready)

	// An empty queue reports all statistics as zero.
	`BQSS_ASSERT_IMPL(a_empty_stats_zero, clk, arst_n, (DEPTH < 32) && rsp.valid && (rsp.count == '0), (rsp.total == '0) && (rsp.average == '0) && (rsp.largest == '0) && (rsp.smallest == '0))

	// A refused enqueue only happens with the queue filled to its depth.
	`BQSS_ASSERT_IMPL(a_full_count, clk, arst_n, rsp.valid && (rsp.status == ST_FULL), 32'(rsp.count) == (DEPTH % 32))

endmodule

/* rtl/bqss_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqss_ctrl
// Sequencer that steps one operation through execute, fetch, entry walk,
// division and result hand-off.
// ----------------------------------------------------------------------------
module bqss_ctrl import bqss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output ctrl_cmd_t cmd,
	input  dp_stat_t  stat
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_FETCH = 6'b000100,
		S_WALK  = 6'b001000,
		S_DIV   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	// The result register may be reloaded once its item is gone or leaving.
	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.need_fetch) begin
					state_d = S_FETCH;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_FETCH: begin
				cmd.fetch     = 1'b1;
				cmd.walk_init = 1'b1;
				state_d       = S_WALK;
			end
			S_WALK: begin
				cmd.walk_run = 1'b1;
				if (stat.walk_done) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

/* rtl/bqss_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqss_dp
// Entry memory kept as a ring, head and fill count, the statistics walk,
// a bit-serial divider for the average, and the result register.
// ----------------------------------------------------------------------------
module bqss_dp import bqss_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_cmd_t                 cmd,
	output dp_stat_t                  stat,
	input  logic [OPCODE_W-1:0]       opcode,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [POSITION_W-1:0]     position,
	output logic [STATUS_W-1:0]       status,
	output logic signed [VALUE_W-1:0] item,
	output logic [MASK_W-1:0]         match_mask,
	output logic [COUNT_W-1:0]        count,
	output logic signed [TOTAL_W-1:0] total,
	output logic signed [VALUE_W-1:0] average,
	output logic signed [VALUE_W-1:0] largest,
	output logic signed [VALUE_W-1:0] smallest
);

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int PW  = CW + 1;
	localparam int SW  = DATA_WIDTH + CW;
	localparam int DCW = $clog2(SW + 1);

	// Logical position i lives at (head + i) modulo DEPTH.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] i);
		logic [PW-1:0] s;
		s = PW'(head) + PW'(i);
		if (s >= PW'(DEPTH)) begin
			s = s - PW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	logic signed [DATA_WIDTH-1:0] mem [DEPTH];
	logic signed [DATA_WIDTH-1:0] rd_q;
	logic [AW-1:0]                rd_addr;
	logic [AW-1:0]                wr_addr;
	logic                         mem_we;

	logic [OPCODE_W-1:0]          op_q;
	logic signed [DATA_WIDTH-1:0] val_q;
	logic [POSITION_W-1:0]        pos_q;
	logic signed [63:0]           value_ext;

	logic [AW-1:0]                head_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                idx_s1;
	logic                         vld_s1;
	logic                         walk_rd;

	logic signed [SW-1:0]         sum_q;
	logic signed [DATA_WIDTH-1:0] big_q;
	logic signed [DATA_WIDTH-1:0] small_q;
	logic [MASK_W-1:0]            mask_q;
	logic [STATUS_W-1:0]          status_q;
	logic signed [DATA_WIDTH-1:0] item_q;

	logic [SW-1:0]                dq_q;
	logic [CW-1:0]                rem_q;
	logic [DCW-1:0]               div_cnt_q;
	logic                         neg_q;
	logic [SW-1:0]                sum_mag;
	logic [CW:0]                  trial;
	logic [CW:0]                  trial_diff;
	logic                         trial_ge;
	logic signed [SW-1:0]         avg_full;

	logic                         empty;
	logic                         full;
	logic                         pos_ok;
	logic [CW-1:0]                pos_idx;
	logic [AW-1:0]                edit_addr;

	logic signed [63:0]           item_ext;
	logic signed [63:0]           sum_ext;
	logic signed [63:0]           avg_ext;
	logic signed [63:0]           big_ext;
	logic signed [63:0]           small_ext;

	assign value_ext = 64'(value);

	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign pos_ok    = (pos_q != '0) && (32'(pos_q) <= 32'(count_q));
	assign pos_idx   = CW'(pos_q - POSITION_W'(1));
	assign edit_addr = phys(head_q, pos_idx);
	assign walk_rd   = (idx_q < count_q);

	assign stat.need_fetch = !empty && ((op_q == OP_DEQUEUE) || ((op_q == OP_EDIT) && pos_ok));
	assign stat.walk_done  = !walk_rd && !vld_s1;
	assign stat.div_done   = (div_cnt_q == '0);

	// Memory port control: the walk reads one entry a cycle; otherwise the
	// read port serves the head (dequeue) or the edited position.
	always_comb begin
		if (cmd.walk_run) begin
			rd_addr = phys(head_q, idx_q);
		end else if (op_q == OP_EDIT) begin
			rd_addr = edit_addr;
		end else begin
			rd_addr = head_q;
		end
		mem_we  = 1'b0;
		wr_addr = edit_addr;
		if (cmd.exec && (op_q == OP_ENQUEUE) && !full) begin
			mem_we  = 1'b1;
			wr_addr = phys(head_q, count_q);
		end else if (cmd.fetch && (op_q == OP_EDIT)) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= val_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			vld_s1    <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.exec) begin
				if ((op_q == OP_ENQUEUE) && !full) begin
					count_q <= count_q + CW'(1);
				end
				if (op_q == OP_CLEAR) begin
					count_q <= '0;
				end
			end
			if (cmd.fetch && (op_q == OP_DEQUEUE)) begin
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_q <= count_q - CW'(1);
			end
			if (cmd.walk_init) begin
				idx_q  <= '0;
				vld_s1 <= 1'b0;
			end else if (cmd.walk_run) begin
				vld_s1 <= walk_rd;
				if (walk_rd) begin
					idx_q <= idx_q + CW'(1);
				end
			end else begin
				vld_s1 <= 1'b0;
			end
			if (cmd.div_start) begin
				div_cnt_q <= DCW'(SW);
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
		end
	end

	// Restoring division of |sum| by the count, one quotient bit a cycle.
	assign sum_mag    = sum_q[SW-1] ? -sum_q : sum_q;
	assign trial      = {rem_q, dq_q[SW-1]};
	assign trial_ge   = (trial >= {1'b0, count_q});
	assign trial_diff = trial - {1'b0, count_q};
	assign avg_full   = empty ? '0 : (neg_q ? -$signed(dq_q) : $signed(dq_q));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			val_q <= value_ext[DATA_WIDTH-1:0];
			pos_q <= position;
		end
		if (cmd.exec) begin
			item_q <= '0;
			mask_q <= '0;
			case (op_q)
				OP_ENQUEUE: begin
					status_q <= full ? ST_FULL : ST_OK;
				end
				OP_DEQUEUE, OP_SEARCH, OP_CLEAR: begin
					status_q <= empty ? ST_EMPTY : ST_OK;
				end
				OP_EDIT: begin
					status_q <= empty ? ST_EMPTY : (pos_ok ? ST_OK : ST_NOT_FOUND);
				end
				default: begin
					status_q <= ST_NOT_FOUND;
				end
			endcase
		end
		if (cmd.fetch) begin
			item_q <= rd_q;
		end
		if (cmd.walk_run) begin
			idx_s1 <= idx_q;
		end
		if (cmd.walk_init) begin
			sum_q   <= '0;
			big_q   <= '0;
			small_q <= '0;
		end else if (vld_s1) begin
			sum_q <= sum_q + SW'(rd_q);
			if ((idx_s1 == '0) || (rd_q > big_q)) begin
				big_q <= rd_q;
			end
			if ((idx_s1 == '0) || (rd_q < small_q)) begin
				small_q <= rd_q;
			end
			if ((op_q == OP_SEARCH) && (32'(idx_s1) < MASK_W) && (rd_q == val_q)) begin
				mask_q[MASK_IDX_W'(idx_s1)] <= 1'b1;
			end
		end
		if (cmd.div_start) begin
			neg_q <= sum_q[SW-1];
			dq_q  <= sum_mag;
			rem_q <= '0;
			if ((op_q == OP_SEARCH) && (status_q == ST_OK) && (mask_q == '0)) begin
				status_q <= ST_NOT_FOUND;
			end
		end else if (div_cnt_q != '0) begin
			dq_q  <= {dq_q[SW-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
		end
	end

	assign item_ext  = 64'(item_q);
	assign sum_ext   = 64'(sum_q);
	assign avg_ext   = 64'(avg_full);
	assign big_ext   = 64'(big_q);
	assign small_ext = 64'(small_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status     <= status_q;
			item       <= item_ext[VALUE_W-1:0];
			match_mask <= mask_q;
			count      <= COUNT_W'(count_q);
			total      <= sum_ext[TOTAL_W-1:0];
			average    <= avg_ext[VALUE_W-1:0];
			largest    <= big_ext[VALUE_W-1:0];
			smallest   <= small_ext[VALUE_W-1:0];
		end
	end

endmodule
